[sv/b64s_pkg.sv]
// shared types and constants for the binary64 square root pipeline
package b64s_pkg;

    localparam int unsigned EXP_W   = 11;
    localparam int unsigned FRAC_W  = 52;
    localparam int unsigned ROOT_W  = 53;
    localparam int unsigned RAD_W   = 106;
    localparam int unsigned REM_W   = 56;
    localparam int unsigned N_ITER  = 53;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [EXP_W:0]   EXP_BIAS     = 12'd1023;

    // control and sideband that travel with each item
    typedef struct packed {
        logic             valid;
        logic             rejected;
        logic [EXP_W-1:0] exp;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_work;

endpackage

[sv/b64s_front.sv]
// operand unpack and radicand setup stage
module b64s_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [63:0]         i_operand_bits,
    output b64s_pkg::t_side     o_side,
    output b64s_pkg::t_work     o_work
);
    import b64s_pkg::*;

    logic [EXP_W-1:0] efield;
    logic [53:0]      sig;
    logic [EXP_W:0]   exp_sum;
    t_side            r_side, n_side;
    t_work            r_work, n_work;

    always_comb begin
        efield  = i_operand_bits[62:52];
        // odd unbiased exponent means even field: double the significand
        if (efield[0]) begin
            sig = {2'b01, i_operand_bits[51:0]};
        end else begin
            sig = {1'b1, i_operand_bits[51:0], 1'b0};
        end
        exp_sum          = {1'b0, efield} + EXP_BIAS;
        n_side.valid     = i_valid;
        n_side.rejected  = (efield == '0) || (efield == EXP_ALL_ONES) || i_operand_bits[63];
        n_side.exp       = exp_sum[EXP_W:1];
        n_work.rad       = {sig, {FRAC_W{1'b0}}};
        n_work.rem       = '0;
        n_work.root      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_ce) begin
            r_side.valid <= n_side.valid;
        end
        if (i_ce) begin
            r_side.rejected <= n_side.rejected;
            r_side.exp      <= n_side.exp;
            r_work          <= n_work;
        end
    end

    assign o_side = r_side;
    assign o_work = r_work;
endmodule

[sv/b64s_stage.sv]
// one restoring square root step: one root bit per stage
module b64s_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  b64s_pkg::t_side     i_side,
    input  b64s_pkg::t_work     i_work,
    output b64s_pkg::t_side     o_side,
    output b64s_pkg::t_work     o_work
);
    import b64s_pkg::*;

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    t_side            r_side;
    t_work            r_work, n_work;

    always_comb begin
        shifted = {i_work.rem[REM_W-3:0], i_work.rad[RAD_W-1 -: 2]};
        trial   = {1'b0, i_work.root, 2'b01};
        n_work.rad = {i_work.rad[RAD_W-3:0], 2'b00};
        if (shifted >= trial) begin
            n_work.rem  = shifted - trial;
            n_work.root = {i_work.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_work.rem  = shifted;
            n_work.root = {i_work.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_ce) begin
            r_side.valid <= i_side.valid;
        end
        if (i_ce) begin
            r_side.rejected <= i_side.rejected;
            r_side.exp      <= i_side.exp;
            r_work          <= n_work;
        end
    end

    assign o_side = r_side;
    assign o_work = r_work;
endmodule

[sv/b64s_round.sv]
// round to nearest, renormalize and pack the result
module b64s_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  b64s_pkg::t_side     i_side,
    input  b64s_pkg::t_work     i_work,
    output logic                o_valid,
    output logic [63:0]         o_root_bits,
    output logic                o_rejected
);
    import b64s_pkg::*;

    logic              up;
    logic [ROOT_W:0]   rounded;
    logic [EXP_W-1:0]  exp_adj;
    logic [63:0]       n_bits;
    logic              r_valid;
    logic [63:0]       r_bits;
    logic              r_rej;

    always_comb begin
        // (2r+1)^2 < 4*rad exactly when the remainder exceeds r
        up      = i_work.rem > {{(REM_W-ROOT_W){1'b0}}, i_work.root};
        rounded = {1'b0, i_work.root} + {{ROOT_W{1'b0}}, up};
        if (rounded[ROOT_W]) begin
            exp_adj = i_side.exp + 11'd1;
            n_bits  = {1'b0, exp_adj, {FRAC_W{1'b0}}};
        end else begin
            exp_adj = i_side.exp;
            n_bits  = {1'b0, exp_adj, rounded[FRAC_W-1:0]};
        end
        if (i_side.rejected) begin
            n_bits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_side.valid;
        end
        if (i_ce) begin
            r_bits <= n_bits;
            r_rej  <= i_side.rejected;
        end
    end

    assign o_valid     = r_valid;
    assign o_root_bits = r_bits;
    assign o_rejected  = r_rej;
endmodule

[sv/binary64_square_root_top.sv]
// binary64 square root: 55-stage pipeline, one item per cycle unless the output stalls
// stages in order: unpack stage, 53 root-bit stages, round/pack stage
// throughput one item per cycle; a stall at the output holds every stage
// synchronous active-low reset clears all valid bits, payload is not reset
module binary64_square_root_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] operand_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] root_bits
    output logic        m_axis_tuser    // [0] rejected
);
    import b64s_pkg::*;

    logic  ce;
    t_side side [N_ITER+1];
    t_work work [N_ITER+1];

    assign ce            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = ce;

    b64s_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ce           (ce),
        .i_valid        (s_axis_tvalid),
        .i_operand_bits (s_axis_tdata),
        .o_side         (side[0]),
        .o_work         (work[0])
    );

    for (genvar g = 0; g < N_ITER; g++) begin : g_stage
        b64s_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_side  (side[g]),
            .i_work  (work[g]),
            .o_side  (side[g+1]),
            .o_work  (work[g+1])
        );
    end

    b64s_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (ce),
        .i_side      (side[N_ITER]),
        .i_work      (work[N_ITER]),
        .o_valid     (m_axis_tvalid),
        .o_root_bits (m_axis_tdata),
        .o_rejected  (m_axis_tuser)
    );
endmodule
